>>> sv/tmaa_pkg.sv
// Package: word types and constants for the triangle mesh area accumulator.
`timescale 1ns / 1ps
package tmaa_pkg;
   localparam int FieldCoordBits = 16;
   localparam int TriBits = 36;
   localparam int TotalBits = 48;
   localparam int TallyBits = 32;

   typedef struct packed {
      logic start_mesh;
      logic face_present;
      logic signed [FieldCoordBits-1:0] p0_x;
      logic signed [FieldCoordBits-1:0] p0_y;
      logic signed [FieldCoordBits-1:0] p0_z;
      logic signed [FieldCoordBits-1:0] p1_x;
      logic signed [FieldCoordBits-1:0] p1_y;
      logic signed [FieldCoordBits-1:0] p1_z;
      logic signed [FieldCoordBits-1:0] p2_x;
      logic signed [FieldCoordBits-1:0] p2_y;
      logic signed [FieldCoordBits-1:0] p2_z;
   } req_type;

   typedef struct packed {
      logic [TriBits-1:0] tri_double_area;
      logic is_degenerate;
      logic [TotalBits-1:0] total_double_area;
      logic [TallyBits-1:0] degenerate_count;
   } rsp_type;
endpackage

>>> sv/triangle_mesh_area_accumulator.sv
// Top level: triangle mesh area accumulator.
//  channel | direction | word     | handshake
//  req_    | in        | req_type | req_valid / req_stall
//  rsp_    | out       | rsp_type | rsp_valid / rsp_stall
// Front end takes one triangle a cycle, when not stalled, into a 3-stage pipeline
// feeding a 4-entry queue. Back end finds each area triangle's root one bit per cycle
// and takes no new entry until done; skipped or degenerate faces skip the root.
// Synchronous active-high reset clears totals, queue and pipeline valids.
// Either side may stall; a full queue back-pressures the front end.
`timescale 1ns / 1ps
module triangle_mesh_area_accumulator import tmaa_pkg::*; #(
   parameter int COORD_BITS = 16,
   parameter int SUM_BITS = 48
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  req_type req_word,
   output logic rsp_valid,
   input  logic rsp_stall,
   output rsp_type rsp_word
);
   localparam int NormBits = 4 * COORD_BITS + 3;
   localparam int QW = NormBits + 3;

   logic f_valid, f_stall, f_start, f_face, f_degen;
   logic [NormBits-1:0] f_norm;
   logic q_valid, q_stall;
   logic [QW-1:0] q_data;

   tmaa_front #(.COORD_BITS(COORD_BITS), .NORM_BITS(NormBits)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_word,
      .fr_valid(f_valid), .fr_stall(f_stall), .fr_start(f_start),
      .fr_face(f_face), .fr_degen(f_degen), .fr_norm(f_norm)
   );

   tmaa_fifo #(.WIDTH(QW)) u_fifo (
      .clock, .reset,
      .in_valid(f_valid), .in_stall(f_stall),
      .in_data({f_start, f_face, f_degen, f_norm}),
      .out_valid(q_valid), .out_stall(q_stall), .out_data(q_data)
   );

   tmaa_back #(.NORM_BITS(NormBits), .SUM_BITS(SUM_BITS)) u_back (
      .clock, .reset, .q_valid, .q_stall,
      .q_start(q_data[QW-1]), .q_face(q_data[QW-2]), .q_degen(q_data[QW-3]),
      .q_norm(q_data[NormBits-1:0]),
      .rsp_valid, .rsp_stall, .rsp_word
   );
endmodule

>>> sv/tmaa_front.sv
// Front end: degeneracy check and squared cross-product length, pipelined.
`timescale 1ns / 1ps
module tmaa_front import tmaa_pkg::*; #(
   parameter int COORD_BITS = 16,
   parameter int NORM_BITS = 4 * COORD_BITS + 3
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  req_type req_word,
   output logic fr_valid,
   input  logic fr_stall,
   output logic fr_start,
   output logic fr_face,
   output logic fr_degen,
   output logic [NORM_BITS-1:0] fr_norm
);
   localparam int DB = COORD_BITS + 1;
   localparam int PB = 2 * DB + 1;
   localparam int SB = 2 * PB;

   logic signed [COORD_BITS-1:0] c_in [9];
   logic v1_ff, v2_ff, v3_ff;
   logic [2:0] f1_ff, f2_ff, f3_ff;
   logic signed [DB-1:0] d_ff [6];
   logic signed [PB-1:0] c_ff [3];
   logic [SB-1:0] n_ff;
   logic adv;

   assign adv = !(v3_ff && fr_stall);
   assign req_stall = !adv;
   assign fr_valid = v3_ff;
   assign fr_start = f3_ff[2];
   assign fr_face = f3_ff[1];
   assign fr_degen = f3_ff[0];
   assign fr_norm = NORM_BITS'(n_ff);

   always_comb begin
      c_in[0] = COORD_BITS'(req_word.p0_x);
      c_in[1] = COORD_BITS'(req_word.p0_y);
      c_in[2] = COORD_BITS'(req_word.p0_z);
      c_in[3] = COORD_BITS'(req_word.p1_x);
      c_in[4] = COORD_BITS'(req_word.p1_y);
      c_in[5] = COORD_BITS'(req_word.p1_z);
      c_in[6] = COORD_BITS'(req_word.p2_x);
      c_in[7] = COORD_BITS'(req_word.p2_y);
      c_in[8] = COORD_BITS'(req_word.p2_z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      if (adv) begin
         f1_ff <= {req_word.start_mesh, req_word.face_present,
                   (c_in[0] == c_in[3] && c_in[1] == c_in[4] && c_in[2] == c_in[5]) ||
                   (c_in[0] == c_in[6] && c_in[1] == c_in[7] && c_in[2] == c_in[8]) ||
                   (c_in[3] == c_in[6] && c_in[4] == c_in[7] && c_in[5] == c_in[8])};
         for (int i = 0; i < 3; i++) begin
            d_ff[i]   <= DB'(c_in[3+i]) - DB'(c_in[i]);
            d_ff[3+i] <= DB'(c_in[6+i]) - DB'(c_in[i]);
         end
         f2_ff <= f1_ff;
         c_ff[0] <= PB'(d_ff[1] * d_ff[5]) - PB'(d_ff[2] * d_ff[4]);
         c_ff[1] <= PB'(d_ff[2] * d_ff[3]) - PB'(d_ff[0] * d_ff[5]);
         c_ff[2] <= PB'(d_ff[0] * d_ff[4]) - PB'(d_ff[1] * d_ff[3]);
         f3_ff <= f2_ff;
         n_ff <= SB'(c_ff[0] * c_ff[0]) + SB'(c_ff[1] * c_ff[1])
               + SB'(c_ff[2] * c_ff[2]);
      end
   end
endmodule

>>> sv/tmaa_fifo.sv
// Short queue between front end and back end.
`timescale 1ns / 1ps
module tmaa_fifo #(
   parameter int WIDTH = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_stall,
   input  logic [WIDTH-1:0] in_data,
   output logic out_valid,
   input  logic out_stall,
   output logic [WIDTH-1:0] out_data
);
   logic [WIDTH-1:0] mem_ff [4];
   logic [1:0] wp_ff, rp_ff;
   logic [2:0] cnt_ff;
   logic wr, rd;

   assign in_stall = cnt_ff[2];
   assign out_valid = cnt_ff != 3'd0;
   assign out_data = mem_ff[rp_ff];
   assign wr = in_valid && !in_stall;
   assign rd = out_valid && !out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (wr) wp_ff <= wp_ff + 2'd1;
         if (rd) rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + 3'(wr) - 3'(rd);
      end
      if (wr) mem_ff[wp_ff] <= in_data;
   end
endmodule

>>> sv/tmaa_back.sv
// Back end: bit-serial integer square root and saturating totals.
`timescale 1ns / 1ps
module tmaa_back import tmaa_pkg::*; #(
   parameter int NORM_BITS = 67,
   parameter int SUM_BITS = 48
) (
   input  logic clock,
   input  logic reset,
   input  logic q_valid,
   output logic q_stall,
   input  logic q_start,
   input  logic q_face,
   input  logic q_degen,
   input  logic [NORM_BITS-1:0] q_norm,
   output logic rsp_valid,
   input  logic rsp_stall,
   output rsp_type rsp_word
);
   localparam int RB = (NORM_BITS + 1) / 2;
   localparam int NB = 2 * RB;
   localparam int CB = $clog2(RB + 1);
   localparam logic [SUM_BITS-1:0] SumMax = '1;

   typedef enum logic [1:0] {IDLE, ROOT, DONE} state_type;
   state_type state_ff;
   logic [NB-1:0] rem_ff, x_ff;
   logic [RB-1:0] root_ff;
   logic [CB-1:0] cnt_ff;
   logic start_ff;
   logic [SUM_BITS-1:0] sum_ff, base;
   logic [TallyBits-1:0] tally_ff, tbase;
   logic [NB+1:0] trial;
   logic [NB-1:0] rem_sh;
   logic [SUM_BITS:0] add;
   logic [SUM_BITS-1:0] rootx;
   logic out_load;

   assign q_stall = state_ff != IDLE || (rsp_valid && rsp_stall);
   assign rem_sh = {rem_ff[NB-3:0], x_ff[NB-1:NB-2]};
   assign trial = {2'b0, rem_sh} - (NB+2)'({root_ff, 2'b01});
   assign base = start_ff ? '0 : sum_ff;
   assign tbase = q_start ? '0 : tally_ff;
   assign rootx = (RB > SUM_BITS) ? SUM_BITS'(root_ff)
                                 : SUM_BITS'({{SUM_BITS{1'b0}}, root_ff});
   assign add = {1'b0, base} + {1'b0, rootx};
   assign out_load = (state_ff == DONE)
                  || (state_ff == IDLE && q_valid && !q_stall && !(q_face && !q_degen));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         rsp_valid <= 1'b0;
         sum_ff <= '0;
         tally_ff <= '0;
      end else begin
         if (out_load) rsp_valid <= 1'b1;
         else if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
         unique case (state_ff)
            IDLE: begin
               if (q_valid && !q_stall) begin
                  if (q_face && !q_degen) begin
                     state_ff <= ROOT;
                     x_ff <= NB'(q_norm);
                     rem_ff <= '0;
                     root_ff <= '0;
                     cnt_ff <= CB'(RB);
                     start_ff <= q_start;
                  end else begin
                     if (q_start) sum_ff <= '0;
                     tally_ff <= (q_face && tbase != '1) ? tbase + 1'b1 : tbase;
                     rsp_word.tri_double_area <= '0;
                     rsp_word.is_degenerate <= q_face;
                     rsp_word.total_double_area <=
                        TotalBits'({{TotalBits{1'b0}}, (q_start ? '0 : sum_ff)});
                     rsp_word.degenerate_count <=
                        (q_face && tbase != '1) ? tbase + 1'b1 : tbase;
                  end
               end
            end
            ROOT: begin
               x_ff <= {x_ff[NB-3:0], 2'b00};
               if (!trial[NB+1]) begin
                  rem_ff <= trial[NB-1:0];
                  root_ff <= {root_ff[RB-2:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh;
                  root_ff <= {root_ff[RB-2:0], 1'b0};
               end
               cnt_ff <= cnt_ff - CB'(1);
               if (cnt_ff == CB'(1)) state_ff <= DONE;
               if (start_ff) tally_ff <= '0;
            end
            DONE: begin
               state_ff <= IDLE;
               sum_ff <= (add[SUM_BITS] || add[SUM_BITS-1:0] == SumMax
                          || (RB > SUM_BITS && (root_ff >> SUM_BITS) != '0))
                         ? SumMax : add[SUM_BITS-1:0];
               rsp_word.tri_double_area <= ((root_ff >> TriBits) != '0) ? '1
                  : TriBits'({{TriBits{1'b0}}, root_ff});
               rsp_word.is_degenerate <= 1'b0;
               rsp_word.total_double_area <= TotalBits'({{TotalBits{1'b0}},
                  ((add[SUM_BITS] || add[SUM_BITS-1:0] == SumMax
                    || (RB > SUM_BITS && (root_ff >> SUM_BITS) != '0))
                   ? SumMax : add[SUM_BITS-1:0])});
               rsp_word.degenerate_count <= tally_ff;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end
endmodule

>>> verif/tb_top.sv
// Testbench: random and directed triangles checked against a local area predictor.
`timescale 1ns / 1ps
class area_scoreboard;
   tmaa_pkg::rsp_type pending[$];
   logic [47:0] sum_q;
   logic [31:0] tally_q;
   int errors;

   function new();
      sum_q = '0;
      tally_q = '0;
      errors = 0;
   endfunction

   function automatic logic [63:0] isqrt(logic [127:0] v);
      logic [63:0] root;
      logic [63:0] cand;
      root = '0;
      for (int b = 63; b >= 0; b--) begin
         cand = root | (64'd1 << b);
         if ({64'd0, cand} * {64'd0, cand} <= v) root = cand;
      end
      return root;
   endfunction

   function void note_triangle(tmaa_pkg::req_type w);
      tmaa_pkg::rsp_type r;
      logic signed [63:0] ax, ay, az, bx, by, bz, cx, cy, cz;
      logic [127:0] sq;
      logic [63:0] root;
      logic [63:0] lim;
      bit same01, same02, same12;
      r = '0;
      lim = (64'd1 << 48) - 1;
      if (w.start_mesh) begin
         sum_q = '0;
         tally_q = '0;
      end
      if (w.face_present) begin
         same01 = {w.p0_x, w.p0_y, w.p0_z} == {w.p1_x, w.p1_y, w.p1_z};
         same02 = {w.p0_x, w.p0_y, w.p0_z} == {w.p2_x, w.p2_y, w.p2_z};
         same12 = {w.p1_x, w.p1_y, w.p1_z} == {w.p2_x, w.p2_y, w.p2_z};
         if (same01 || same02 || same12) begin
            r.is_degenerate = 1'b1;
            if (tally_q != '1) tally_q++;
         end else begin
            ax = 64'(w.p1_x) - 64'(w.p0_x);
            ay = 64'(w.p1_y) - 64'(w.p0_y);
            az = 64'(w.p1_z) - 64'(w.p0_z);
            bx = 64'(w.p2_x) - 64'(w.p0_x);
            by = 64'(w.p2_y) - 64'(w.p0_y);
            bz = 64'(w.p2_z) - 64'(w.p0_z);
            cx = ay * bz - az * by;
            cy = az * bx - ax * bz;
            cz = ax * by - ay * bx;
            sq = 128'(cx * cx) + 128'(cy * cy) + 128'(cz * cz);
            root = isqrt(sq);
            r.tri_double_area = (root > 64'h0F_FFFF_FFFF) ? '1 : root[35:0];
            if (root >= lim - {16'd0, sum_q}) sum_q = '1;
            else sum_q = sum_q + root[47:0];
         end
      end
      r.total_double_area = sum_q;
      r.degenerate_count = tally_q;
      pending = {pending, r};
   endfunction

   function void check_result(tmaa_pkg::rsp_type got);
      tmaa_pkg::rsp_type exp;
      if (pending.size() == 0) begin
         $display("%0t unexpected word: got %h", $time, got);
         errors++;
         return;
      end
      exp = pending.pop_front();
      if (got.tri_double_area !== exp.tri_double_area) begin
         $display("%0t tri_double_area: expected %0d actual %0d", $time,
                  exp.tri_double_area, got.tri_double_area);
         errors++;
      end
      if (got.is_degenerate !== exp.is_degenerate) begin
         $display("%0t is_degenerate: expected %0d actual %0d", $time,
                  exp.is_degenerate, got.is_degenerate);
         errors++;
      end
      if (got.total_double_area !== exp.total_double_area) begin
         $display("%0t total_double_area: expected %0d actual %0d", $time,
                  exp.total_double_area, got.total_double_area);
         errors++;
      end
      if (got.degenerate_count !== exp.degenerate_count) begin
         $display("%0t degenerate_count: expected %0d actual %0d", $time,
                  exp.degenerate_count, got.degenerate_count);
         errors++;
      end
   endfunction
endclass

module tb_top;
   import tmaa_pkg::*;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_word;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_word;

   area_scoreboard board;
   bit long_hold;
   int cycle_count;

   triangle_mesh_area_accumulator i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word(rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      board = new();
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 2000000) begin
         $display("TEST FAILED");
         $finish;
      end
      if (!reset) begin
         if (req_valid && !req_stall) board.note_triangle(req_word);
         if (rsp_valid && !rsp_stall) board.check_result(rsp_word);
      end
   end

   function automatic logic [15:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'($urandom_range(0, 15)) - 16'd8;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_type rand_triangle();
      req_type w;
      w.start_mesh = ($urandom_range(0, 39) == 0);
      w.face_present = ($urandom_range(0, 9) != 0);
      {w.p0_x, w.p0_y, w.p0_z} = {rand_coord(), rand_coord(), rand_coord()};
      {w.p1_x, w.p1_y, w.p1_z} = {rand_coord(), rand_coord(), rand_coord()};
      {w.p2_x, w.p2_y, w.p2_z} = {rand_coord(), rand_coord(), rand_coord()};
      case ($urandom_range(0, 11))
         0: {w.p1_x, w.p1_y, w.p1_z} = {w.p0_x, w.p0_y, w.p0_z};
         1: {w.p2_x, w.p2_y, w.p2_z} = {w.p0_x, w.p0_y, w.p0_z};
         2: {w.p2_x, w.p2_y, w.p2_z} = {w.p1_x, w.p1_y, w.p1_z};
         default: ;
      endcase
      return w;
   endfunction

   function automatic req_type make_triangle(bit sm, bit fp, logic [15:0] a, logic [15:0] b,
                                             logic [15:0] c, logic [15:0] d);
      req_type w;
      w.start_mesh = sm;
      w.face_present = fp;
      {w.p0_x, w.p0_y, w.p0_z} = {a, a, b};
      {w.p1_x, w.p1_y, w.p1_z} = {c, a, b};
      {w.p2_x, w.p2_y, w.p2_z} = {a, d, c};
      return w;
   endfunction

   task automatic send_word(req_type w);
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic idle_cycles(int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // receiver stall pattern, with one long hold-off
   initial begin
      rsp_stall = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (long_hold) rsp_stall <= 1'b1;
         else case ($urandom_range(0, 3))
            0: rsp_stall <= ($urandom_range(0, 1) == 1);
            1: rsp_stall <= ($urandom_range(0, 7) == 0);
            default: rsp_stall <= 1'b0;
         endcase
      end
   end

   initial begin
      req_type w;
      int sent;
      int burst;
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      long_hold = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, skipped face, degenerate, clears
      send_word(make_triangle(1, 1, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF));
      send_word(make_triangle(0, 1, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000));
      send_word(make_triangle(0, 0, 16'h0001, 16'h0002, 16'h0003, 16'h0004));
      send_word(make_triangle(0, 1, 16'h0005, 16'h0005, 16'h0005, 16'h0005));
      send_word(make_triangle(0, 1, 16'h0000, 16'h0000, 16'h0001, 16'h0001));
      send_word(make_triangle(1, 0, 16'hFFFF, 16'h0000, 16'h0001, 16'h0002));
      send_word(make_triangle(0, 1, 16'hFFFF, 16'h0000, 16'hFFFE, 16'h0001));
      send_word(make_triangle(0, 1, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555));
      w = '0;
      w.face_present = 1'b1;
      {w.p0_x, w.p0_y, w.p0_z} = {16'h8000, 16'h8000, 16'h8000};
      {w.p1_x, w.p1_y, w.p1_z} = {16'h7FFF, 16'h8000, 16'h7FFF};
      {w.p2_x, w.p2_y, w.p2_z} = {16'h8000, 16'h7FFF, 16'h7FFF};
      send_word(w);
      // large triangles repeatedly to push the running sum upward
      for (int i = 0; i < 12; i++) send_word(w);
      idle_cycles(3);

      // long receiver hold-off while the sender keeps offering
      fork
         begin
            long_hold = 1'b1;
            repeat (400) @(posedge clock);
            long_hold = 1'b0;
         end
         for (int i = 0; i < 20; i++) send_word(rand_triangle());
      join

      sent = 0;
      while (sent < 950) begin
         burst = $urandom_range(1, 30);
         for (int i = 0; i < burst; i++) send_word(rand_triangle());
         sent += burst;
         if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 40));
      end
      req_valid <= 1'b0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
